[rtl/spcgr_pkg.sv]
// Shared constants, codes and types for the SPC gauge serial reader.
package spcgr_pkg;

    // Frame geometry
    localparam int FRAME_NIBBLES = 13;
    localparam int BIT_IDX_W     = 6;
    localparam int NIB_IDX_W     = 4;
    localparam int NIB_W         = 4;

    // Field widths
    localparam int LIMIT_W   = 24;
    localparam int MAG_W     = 18;
    localparam int READING_W = 19;

    // Reset and limit values
    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 24'd6500000;
    localparam logic [LIMIT_W-1:0] COUNT_MAX     = 24'hFFFFFF;

    // Nibble positions and codes inside a frame
    localparam logic [NIB_IDX_W-1:0] NIB_SIGN      = 4'd4;
    localparam logic [NIB_IDX_W-1:0] NIB_DIGIT_LO  = 4'd5;
    localparam logic [NIB_IDX_W-1:0] NIB_DIGIT_HI  = 4'd9;
    localparam logic [NIB_IDX_W-1:0] NIB_UNITS     = 4'd12;
    localparam logic [NIB_W-1:0]     SIGN_NEGATIVE = 4'b1000;
    localparam logic [NIB_W-1:0]     UNITS_INCH    = 4'b0001;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    // Per-tick result from the frame decoder
    typedef struct packed {
        logic                        request_active;
        logic                        frame_done;
        logic                        status;
        logic signed [READING_W-1:0] reading;
        logic                        inch_units;
        logic                        busy_res;
    } result_t;

endpackage

[rtl/spcgr_frame.sv]
// Frame decoder: request, clock edge tracking, nibble assembly and value folding.
module spcgr_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          start_req,
    input  logic                          gauge_clock,
    input  logic                          gauge_data,
    input  logic [spcgr_pkg::LIMIT_W-1:0] timeout_limit,
    output spcgr_pkg::result_t            result
);

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
    localparam logic [1:0] PH_WAIT_FALL = 2'd2;

    logic [1:0]                        phase_reg, phase_next;
    logic [spcgr_pkg::BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [spcgr_pkg::NIB_W-1:0]       nib_reg, nib_next;
    logic [spcgr_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic                              neg_reg, neg_next;
    logic                              inch_reg, inch_next;
    logic [spcgr_pkg::LIMIT_W-1:0]     cnt_reg, cnt_next;
    logic                              req_reg, req_next;

    logic [1:0]                        pos;
    logic [spcgr_pkg::NIB_IDX_W-1:0]   which;
    logic [spcgr_pkg::NIB_W-1:0]       nib;
    logic [spcgr_pkg::READING_W-1:0]   mag_ext;

    assign pos     = bit_idx_reg[1:0];
    assign which   = bit_idx_reg[spcgr_pkg::BIT_IDX_W-1:2];
    assign nib     = nib_reg | ({{(spcgr_pkg::NIB_W-1){1'b0}}, gauge_data} << pos);

    // Work out next state and this tick's result
    always_comb
    begin
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        nib_next     = nib_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        inch_next    = inch_reg;
        cnt_next     = cnt_reg;
        req_next     = req_reg;
        mag_ext      = '0;

        result.frame_done = 1'b0;
        result.status     = spcgr_pkg::STATUS_OK;
        result.reading    = '0;
        result.inch_units = 1'b0;

        case (phase_reg)
            PH_WAIT_HIGH:
            begin
                // Gauge answered: release the request and start timing the high level
                if (gauge_clock)
                begin
                    req_next   = 1'b0;
                    cnt_next   = '0;
                    phase_next = PH_WAIT_FALL;
                end
            end
            PH_WAIT_FALL:
            begin
                if (gauge_clock)
                begin
                    // Abort on a clock held high too long, else count with saturation
                    if (cnt_reg > timeout_limit)
                    begin
                        result.frame_done = 1'b1;
                        result.status     = spcgr_pkg::STATUS_TIMEOUT;
                        phase_next        = PH_IDLE;
                        req_next          = 1'b0;
                        bit_idx_next      = '0;
                        nib_next          = '0;
                        mag_next          = '0;
                        neg_next          = 1'b0;
                        inch_next         = 1'b0;
                        cnt_next          = '0;
                    end
                    else if (cnt_reg != spcgr_pkg::COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (pos == 2'd3)
                begin
                    // Nibble complete: fold it into sign, magnitude or units
                    if (which == spcgr_pkg::NIB_SIGN)
                        neg_next = (nib == spcgr_pkg::SIGN_NEGATIVE);
                    else if (which >= spcgr_pkg::NIB_DIGIT_LO &&
                             which <= spcgr_pkg::NIB_DIGIT_HI)
                        mag_next = (mag_reg << 3) + (mag_reg << 1) +
                                   {{(spcgr_pkg::MAG_W-spcgr_pkg::NIB_W){1'b0}}, nib};
                    else if (which == spcgr_pkg::NIB_UNITS)
                        inch_next = (nib == spcgr_pkg::UNITS_INCH);
                    nib_next = '0;

                    if (which >= spcgr_pkg::NIB_IDX_W'(spcgr_pkg::FRAME_NIBBLES - 1))
                    begin
                        // Last nibble: hand out the signed count and go idle
                        mag_ext           = {1'b0, mag_next};
                        result.frame_done = 1'b1;
                        result.status     = spcgr_pkg::STATUS_OK;
                        result.reading    = neg_next ? -mag_ext : mag_ext;
                        result.inch_units = inch_next;
                        phase_next        = PH_IDLE;
                        bit_idx_next      = '0;
                        mag_next          = '0;
                        neg_next          = 1'b0;
                        inch_next         = 1'b0;
                        cnt_next          = '0;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 1'b1;
                        phase_next   = PH_WAIT_HIGH;
                    end
                end
                else
                begin
                    // Falling edge inside a nibble: keep the bit, wait for next high
                    nib_next     = nib;
                    bit_idx_next = bit_idx_reg + 1'b1;
                    phase_next   = PH_WAIT_HIGH;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    bit_idx_next = '0;
                    nib_next     = '0;
                    mag_next     = '0;
                    neg_next     = 1'b0;
                    inch_next    = 1'b0;
                    cnt_next     = '0;
                    req_next     = 1'b1;
                    phase_next   = PH_WAIT_HIGH;
                end
            end
        endcase

        result.request_active = req_next;
        result.busy_res       = (phase_next != PH_IDLE);
    end

    // Advance state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_idx_reg <= '0;
            nib_reg     <= '0;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            inch_reg    <= 1'b0;
            cnt_reg     <= '0;
            req_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
            nib_reg     <= nib_next;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            inch_reg    <= inch_next;
            cnt_reg     <= cnt_next;
            req_reg     <= req_next;
        end
    end

endmodule

[rtl/spc_gauge_serial_reader_core.sv]
// Top level of the SPC gauge serial reader: stream ports, limit register, output register.
//
//  channel | direction | handshake          | content
//  --------+-----------+--------------------+------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | one tick of start command and pin samples
//  m_*     | out       | m_tvalid/m_tready  | one result item per accepted tick
//  cfg_*   | in        | cfg_valid/cfg_ready| timeout limit write
//
// The decoder state and the result are settled in the cycle an item is accepted, and
// the result shows in the output register on the next cycle.
// Reset clears the frame state, releases the request and loads the default limit.
// A result waiting on m_tready holds; a new item is taken in the same cycle the
// waiting one leaves. Limit writes are always taken.
module spc_gauge_serial_reader_core (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: [0] start_req, [1] gauge_clock, [2] gauge_data, [7:3] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // tdata: [0] request_active, [19:1] reading, [20] busy_res, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    // tuser: [0] status, [1] inch_units
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [spcgr_pkg::LIMIT_W-1:0] cfg_data
);

    logic [spcgr_pkg::LIMIT_W-1:0] limit_reg;
    logic                          m_valid_reg;
    spcgr_pkg::result_t            res_reg;
    spcgr_pkg::result_t            res;
    logic                          accept;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Hold the timeout limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= spcgr_pkg::TIMEOUT_RESET;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    spcgr_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .start_req     (s_tdata[0]),
        .gauge_clock   (s_tdata[1]),
        .gauge_data    (s_tdata[2]),
        .timeout_limit (limit_reg),
        .result        (res)
    );

    // Output register: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.busy_res, res_reg.reading, res_reg.request_active};
    assign m_tlast  = res_reg.frame_done;
    assign m_tuser  = {res_reg.inch_units, res_reg.status};

endmodule
